[sv/sbd_pkg.sv]
// ----------------------------------------------------------------------------
// sbd_pkg
// Shared widths, register indexes, reset values and types of the
// single-button dimmer.
// ----------------------------------------------------------------------------
package sbd_pkg;

    localparam int LEVEL_W = 16;
    localparam int STEP_W  = 15;
    localparam int TICK_W  = 16;
    localparam int EDGE_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DIM_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOTIFY_PERIOD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL   = 2'd3;

    localparam logic [TICK_W-1:0]  RST_DIM_THRESHOLD = 16'd500;
    localparam logic [STEP_W-1:0]  RST_RAMP_STEP     = 15'd66;
    localparam logic [TICK_W-1:0]  RST_NOTIFY_PERIOD = 16'd40;
    localparam logic [LEVEL_W-1:0] RST_START_LEVEL   = 16'd32768;

    localparam logic [LEVEL_W:0]   FULL_SCALE  = 17'd65535;
    localparam logic [LEVEL_W:0]   TWICE_FULL  = 17'd131070;
    localparam logic [EDGE_W-1:0]  EDGE_MAX    = 24'hFFFFFF;

    typedef struct packed {
        logic [LEVEL_W-1:0] brightness;
        logic               brightness_valid;
        logic               power_on;
        logic               power_changed;
        logic               dim_up;
    } t_result;

endpackage

[sv/single_button_dimmer_core.sv]
// ----------------------------------------------------------------------------
// single_button_dimmer_core
// Push-button dimmer: click toggles power, hold ramps brightness as a
// triangle wave, periodic brightness and power notifications.
// ----------------------------------------------------------------------------
// Each transaction (a time tick or a switch edge) is handled combinationally:
// the next state is computed from the stored state and the incoming
// item, and the result lands in a single output register in the cycle after
// acceptance. A new item is taken every cycle as long as the output register
// is empty or is being drained in the same cycle, so the sustained rate is
// one item per clock. Configuration writes take effect at once; writing the
// start brightness also loads the current level.
module single_button_dimmer_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_req_type,
    input  logic                               i_switch_on,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [sbd_pkg::LEVEL_W-1:0]        o_brightness,
    output logic                               o_brightness_valid,
    output logic                               o_power_on,
    output logic                               o_power_changed,
    output logic                               o_dim_up,
    input  logic                               i_cfg_we,
    input  logic [sbd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [sbd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // configuration
    logic [sbd_pkg::TICK_W-1:0]  r_dim_threshold;
    logic [sbd_pkg::STEP_W-1:0]  r_ramp_step;
    logic [sbd_pkg::TICK_W-1:0]  r_notify_period;

    // dimmer state
    logic [sbd_pkg::LEVEL_W-1:0] r_level, n_level;
    logic                        r_rising, n_rising;
    logic                        r_held, n_held;
    logic                        r_powered, n_powered;
    logic [sbd_pkg::EDGE_W-1:0]  r_since_edge, n_since_edge;
    logic [sbd_pkg::TICK_W-1:0]  r_notify_count, n_notify_count;

    // output register
    logic                        r_out_valid;
    sbd_pkg::t_result            r_res, n_res;

    logic                        accept;
    logic [sbd_pkg::TICK_W-1:0]  period;
    logic [sbd_pkg::EDGE_W-1:0]  threshold_ext;
    logic [sbd_pkg::EDGE_W-1:0]  period_ext;
    logic [sbd_pkg::EDGE_W-1:0]  since_inc;
    logic [sbd_pkg::LEVEL_W:0]   ramp_sum;
    logic [sbd_pkg::LEVEL_W:0]   ramp_reflect;
    logic [sbd_pkg::LEVEL_W-1:0] ramp_level;
    logic                        ramp_rising;
    logic [sbd_pkg::TICK_W:0]    count_inc;
    logic                        notify;
    logic                        changed;

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    assign period        = (r_notify_period == '0) ? sbd_pkg::TICK_W'(1) : r_notify_period;
    assign threshold_ext = {{(sbd_pkg::EDGE_W-sbd_pkg::TICK_W){1'b0}}, r_dim_threshold};
    assign period_ext    = {{(sbd_pkg::EDGE_W-sbd_pkg::TICK_W){1'b0}}, period};
    assign since_inc     = (r_since_edge == sbd_pkg::EDGE_MAX) ? r_since_edge
                                                               : r_since_edge + 24'd1;
    assign count_inc     = {1'b0, r_notify_count} + 17'd1;

    // one ramp step with reflection at both ends
    assign ramp_sum     = {1'b0, r_level} + {2'b00, r_ramp_step};
    assign ramp_reflect = sbd_pkg::TWICE_FULL - ramp_sum;

    always_comb begin
        if (r_rising) begin
            if (ramp_sum >= sbd_pkg::FULL_SCALE) begin
                ramp_level  = ramp_reflect[sbd_pkg::LEVEL_W-1:0];
                ramp_rising = 1'b0;
            end else begin
                ramp_level  = ramp_sum[sbd_pkg::LEVEL_W-1:0];
                ramp_rising = 1'b1;
            end
        end else begin
            if (r_level <= {1'b0, r_ramp_step}) begin
                ramp_level  = {1'b0, r_ramp_step} - r_level;
                ramp_rising = 1'b1;
            end else begin
                ramp_level  = r_level - {1'b0, r_ramp_step};
                ramp_rising = 1'b0;
            end
        end
    end

    always_comb begin
        n_level        = r_level;
        n_rising       = r_rising;
        n_held         = r_held;
        n_powered      = r_powered;
        n_since_edge   = r_since_edge;
        n_notify_count = r_notify_count;
        notify         = 1'b0;
        changed        = 1'b0;
        if (i_req_type) begin
            // release before the threshold is a click
            if (r_held && !i_switch_on && (r_since_edge < threshold_ext)) begin
                n_powered = !r_powered;
                changed   = 1'b1;
            end
            n_held       = i_switch_on;
            n_since_edge = '0;
        end else begin
            n_since_edge = since_inc;
            if (r_held && (since_inc > threshold_ext)) begin
                n_level  = ramp_level;
                n_rising = ramp_rising;
            end
            if (count_inc >= {1'b0, period}) begin
                n_notify_count = '0;
                if (r_held && (since_inc >= threshold_ext) && !r_powered) begin
                    n_powered = 1'b1;
                    changed   = 1'b1;
                end
                if (r_held || (since_inc <= period_ext)) begin
                    notify = 1'b1;
                end
            end else begin
                n_notify_count = count_inc[sbd_pkg::TICK_W-1:0];
            end
        end
        n_res.brightness       = n_level;
        n_res.brightness_valid = notify;
        n_res.power_on         = n_powered;
        n_res.power_changed    = changed;
        n_res.dim_up           = n_rising;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dim_threshold <= sbd_pkg::RST_DIM_THRESHOLD;
            r_ramp_step     <= sbd_pkg::RST_RAMP_STEP;
            r_notify_period <= sbd_pkg::RST_NOTIFY_PERIOD;
            r_level         <= sbd_pkg::RST_START_LEVEL;
            r_rising        <= 1'b1;
            r_held          <= 1'b0;
            r_powered       <= 1'b0;
            r_since_edge    <= '0;
            r_notify_count  <= '0;
        end else begin
            if (accept) begin
                r_level        <= n_level;
                r_rising       <= n_rising;
                r_held         <= n_held;
                r_powered      <= n_powered;
                r_since_edge   <= n_since_edge;
                r_notify_count <= n_notify_count;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sbd_pkg::REG_DIM_THRESHOLD: begin
                        r_dim_threshold <= i_cfg_data;
                    end
                    sbd_pkg::REG_RAMP_STEP: begin
                        r_ramp_step <= i_cfg_data[sbd_pkg::STEP_W-1:0];
                    end
                    sbd_pkg::REG_NOTIFY_PERIOD: begin
                        r_notify_period <= i_cfg_data;
                    end
                    sbd_pkg::REG_START_LEVEL: begin
                        r_level <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_brightness       = r_res.brightness;
    assign o_brightness_valid = r_res.brightness_valid;
    assign o_power_on         = r_res.power_on;
    assign o_power_changed    = r_res.power_changed;
    assign o_dim_up           = r_res.dim_up;

    // switch edges never move the level
    a_edge_keeps_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req_type && !i_cfg_we) |=> (r_level == $past(r_level)))
        else $error("level changed on a switch edge");

    // notifications only come from ticks
    a_edge_no_notify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req_type) |=> !r_res.brightness_valid)
        else $error("brightness notification on a switch edge");

    // reported power change matches the stored power state
    a_power_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_res.power_changed == (r_powered != $past(r_powered))))
        else $error("power change flag disagrees with power state");

    // notify counter stays inside the period after a tick
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !i_req_type && !i_cfg_we) |=> (r_notify_count < period))
        else $error("notify counter out of range");

endmodule

[verif/dimmer_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dimmer_checker
// Watches the item, result and register ports of the dimmer core, keeps its
// own copy of the dimmer state, predicts every result and compares it field
// by field with what the core delivers.
// ----------------------------------------------------------------------------
module dimmer_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic                           o_ready,
    input  logic                           i_req_type,
    input  logic                           i_switch_on,
    input  logic                           o_valid,
    input  logic                           i_ready,
    input  logic [sbd_pkg::LEVEL_W-1:0]    o_brightness,
    input  logic                           o_brightness_valid,
    input  logic                           o_power_on,
    input  logic                           o_power_changed,
    input  logic                           o_dim_up,
    input  logic                           i_cfg_we,
    input  logic [sbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [sbd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_pending,
    output int                             o_mismatches
);

    // register copies
    logic [sbd_pkg::TICK_W-1:0]  hold_threshold;
    logic [sbd_pkg::STEP_W-1:0]  ramp_step;
    logic [sbd_pkg::TICK_W-1:0]  notify_period;

    // dimmer state
    logic [sbd_pkg::LEVEL_W-1:0] level;
    logic                        rising;
    logic                        held;
    logic                        powered;
    logic [sbd_pkg::EDGE_W-1:0]  since_edge;
    logic [sbd_pkg::TICK_W:0]    notify_count;

    sbd_pkg::t_result expected_reports[$];
    int               pending    = 0;
    int               mismatches = 0;

    assign o_pending    = pending;
    assign o_mismatches = mismatches;

    task automatic ramp_level();
        logic [sbd_pkg::LEVEL_W:0] sum;
        if (rising) begin
            sum = {1'b0, level} + {2'b00, ramp_step};
            if (sum >= sbd_pkg::FULL_SCALE) begin
                // reflect off full scale
                sum    = sbd_pkg::TWICE_FULL - sum;
                level  = sum[sbd_pkg::LEVEL_W-1:0];
                rising = 1'b0;
            end else begin
                level = sum[sbd_pkg::LEVEL_W-1:0];
            end
        end else if (level <= {1'b0, ramp_step}) begin
            level  = {1'b0, ramp_step} - level;
            rising = 1'b1;
        end else begin
            level = level - {1'b0, ramp_step};
        end
    endtask

    task automatic dimmer_advance(input logic is_edge, input logic pressed,
                                  output sbd_pkg::t_result res);
        logic [sbd_pkg::TICK_W:0] period;
        logic                     notify;
        logic                     changed;
        notify  = 1'b0;
        changed = 1'b0;
        if (is_edge) begin
            // a release before the threshold is a click
            if (held && !pressed && since_edge < {8'd0, hold_threshold}) begin
                powered = !powered;
                changed = 1'b1;
            end
            held       = pressed;
            since_edge = '0;
        end else begin
            period = (notify_period == '0) ? 17'd1 : {1'b0, notify_period};
            if (since_edge != sbd_pkg::EDGE_MAX)
                since_edge = since_edge + 1'b1;
            if (held && since_edge > {8'd0, hold_threshold})
                ramp_level();
            notify_count = notify_count + 1'b1;
            if (notify_count >= period) begin
                notify_count = '0;
                if (held && since_edge >= {8'd0, hold_threshold} && !powered) begin
                    powered = 1'b1;
                    changed = 1'b1;
                end
                if (held || since_edge <= {7'd0, period})
                    notify = 1'b1;
            end
        end
        res.brightness       = level;
        res.brightness_valid = notify;
        res.power_on         = powered;
        res.power_changed    = changed;
        res.dim_up           = rising;
    endtask

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        sbd_pkg::t_result want;
        sbd_pkg::t_result fresh;
        if (!i_rst_n) begin
            hold_threshold = sbd_pkg::RST_DIM_THRESHOLD;
            ramp_step      = sbd_pkg::RST_RAMP_STEP;
            notify_period  = sbd_pkg::RST_NOTIFY_PERIOD;
            level          = sbd_pkg::RST_START_LEVEL;
            rising         = 1'b1;
            held           = 1'b0;
            powered        = 1'b0;
            since_edge     = '0;
            notify_count   = '0;
            expected_reports.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sbd_pkg::REG_DIM_THRESHOLD: hold_threshold = i_cfg_data;
                    sbd_pkg::REG_RAMP_STEP:     ramp_step = i_cfg_data[sbd_pkg::STEP_W-1:0];
                    sbd_pkg::REG_NOTIFY_PERIOD: notify_period  = i_cfg_data;
                    sbd_pkg::REG_START_LEVEL:   level          = i_cfg_data;
                    default: ;
                endcase
            end
            // results leave before the new transaction is predicted
            if (o_valid && i_ready) begin
                if (expected_reports.size() == 0) begin
                    $error("result arrived with no transaction outstanding");
                    mismatches++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("brightness", want.brightness, o_brightness);
                    check_field("brightness_valid", want.brightness_valid,
                                o_brightness_valid);
                    check_field("power_on", want.power_on, o_power_on);
                    check_field("power_changed", want.power_changed, o_power_changed);
                    check_field("dim_up", want.dim_up, o_dim_up);
                end
            end
            if (i_valid && o_ready) begin
                dimmer_advance(i_req_type, i_switch_on, fresh);
                expected_reports.push_back(fresh);
            end
        end
        pending <= expected_reports.size();
    end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives ticks and switch edges into the dimmer core under a range of
// register settings, with random gaps and back-pressure; the checker beside
// the core predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_EDGE = 1'b1;
    localparam int RANDOM_ITEMS = 1000;
    localparam int PHASE_ITEMS  = 60;
    localparam int CYCLE_LIMIT  = 200000;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           i_valid     = 1'b0;
    logic                           i_req_type  = 1'b0;
    logic                           i_switch_on = 1'b0;
    logic                           i_ready     = 1'b0;
    logic                           i_cfg_we    = 1'b0;
    logic [sbd_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [sbd_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                           o_ready;
    logic                           o_valid;
    logic [sbd_pkg::LEVEL_W-1:0]    o_brightness;
    logic                           o_brightness_valid;
    logic                           o_power_on;
    logic                           o_power_changed;
    logic                           o_dim_up;

    int          pending;
    int          mismatches;
    int          cycle_count   = 0;
    int          items_sent    = 0;
    int          directed_sent = 0;
    int          phase         = 0;
    logic [15:0] cur_threshold = sbd_pkg::RST_DIM_THRESHOLD;
    logic        burst_mode    = 1'b0;

    single_button_dimmer_core u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_req_type         (i_req_type),
        .i_switch_on        (i_switch_on),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_brightness       (o_brightness),
        .o_brightness_valid (o_brightness_valid),
        .o_power_on         (o_power_on),
        .o_power_changed    (o_power_changed),
        .o_dim_up           (o_dim_up),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    dimmer_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_req_type         (i_req_type),
        .i_switch_on        (i_switch_on),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_brightness       (o_brightness),
        .o_brightness_valid (o_brightness_valid),
        .o_power_on         (o_power_on),
        .o_power_changed    (o_power_changed),
        .o_dim_up           (o_dim_up),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .o_pending          (pending),
        .o_mismatches       (mismatches)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[single_button_dimmer_core] ERROR");
            $finish;
        end
    end

    // result side back-pressure
    always @(posedge i_clk) begin
        i_ready <= burst_mode || ($urandom_range(0, 99) >= 31);
    end

    task automatic send_item(input logic req, input logic pressed);
        while (!burst_mode && $urandom_range(0, 99) < 31) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_req_type  <= req;
        i_switch_on <= pressed;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // wait until every outstanding transaction has returned
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] thr, input logic [15:0] step,
                             input logic [15:0] period, input logic [15:0] start);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= sbd_pkg::REG_DIM_THRESHOLD;
        i_cfg_data  <= thr;
        @(posedge i_clk);
        i_cfg_index <= sbd_pkg::REG_RAMP_STEP;
        i_cfg_data  <= step;
        @(posedge i_clk);
        i_cfg_index <= sbd_pkg::REG_NOTIFY_PERIOD;
        i_cfg_data  <= period;
        @(posedge i_clk);
        i_cfg_index <= sbd_pkg::REG_START_LEVEL;
        i_cfg_data  <= start;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        cur_threshold  = thr;
    endtask

    task automatic random_phase();
        logic [15:0] thr;
        logic [15:0] step;
        logic [15:0] period;
        logic [15:0] start;
        int          first_item;
        int          hold_max;
        int          hold;
        case ($urandom_range(0, 9))
            0:       thr = 16'd0;
            1:       thr = 16'hFFFF;
            default: thr = 16'($urandom_range(1, 12));
        endcase
        case ($urandom_range(0, 9))
            0:       step = 16'd0;
            1:       step = 16'hFFFF;
            2:       step = 16'h7FFF;
            3:       step = 16'd1;
            default: step = 16'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 9))
            0:       period = 16'd0;
            1:       period = 16'hFFFF;
            default: period = 16'($urandom_range(1, 6));
        endcase
        case ($urandom_range(0, 5))
            0:       start = 16'd0;
            1:       start = 16'hFFFF;
            default: start = 16'($urandom_range(0, 65535));
        endcase
        configure(thr, step, period, start);
        first_item = items_sent;
        while (items_sent - first_item < PHASE_ITEMS) begin
            if ($urandom_range(0, 99) < 80) begin
                // press, hold for a while, release, settle
                hold_max = (cur_threshold > 20) ? 48 : 2 * cur_threshold + 8;
                hold     = $urandom_range(0, hold_max);
                send_item(REQ_EDGE, 1'b1);
                repeat (hold) send_item(REQ_TICK, $urandom_range(0, 1) != 0);
                send_item(REQ_EDGE, 1'b0);
                repeat ($urandom_range(0, 6)) send_item(REQ_TICK, $urandom_range(0, 1) != 0);
            end else begin
                send_item($urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
            end
        end
        drain();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // big step with its top bit masked off, notification on every tick
        configure(16'd2, 16'hFFFF, 16'd0, 16'hFFFF);
        send_item(REQ_TICK, 1'b1);
        send_item(REQ_EDGE, 1'b1);
        repeat (4) send_item(REQ_TICK, 1'b0);
        send_item(REQ_EDGE, 1'b0);
        send_item(REQ_EDGE, 1'b1);
        send_item(REQ_EDGE, 1'b0);
        // repeated release keeps the level
        send_item(REQ_EDGE, 1'b0);
        send_item(REQ_TICK, 1'b1);
        drain();

        // zero threshold and zero step at the bottom, longest period
        configure(16'd0, 16'd0, 16'hFFFF, 16'd0);
        send_item(REQ_EDGE, 1'b1);
        repeat (2) send_item(REQ_TICK, 1'b0);
        send_item(REQ_EDGE, 1'b1);
        send_item(REQ_TICK, 1'b1);
        send_item(REQ_EDGE, 1'b0);
        drain();

        // ramp lands exactly on full scale
        configure(16'd1, 16'd66, 16'd3, 16'd65469);
        send_item(REQ_EDGE, 1'b1);
        repeat (3) send_item(REQ_TICK, 1'b0);
        send_item(REQ_EDGE, 1'b0);
        drain();

        directed_sent = items_sent;
        while (items_sent - directed_sent < RANDOM_ITEMS) begin
            burst_mode = (phase >= 4 && phase <= 6);
            random_phase();
            phase++;
        end
        burst_mode = 1'b0;
        drain();

        if (mismatches == 0 && pending == 0)
            $display("[single_button_dimmer_core] OK");
        else
            $display("[single_button_dimmer_core] ERROR");
        $finish;
    end

endmodule
